// File: hw/rtl/assignment_reduction_solver_macros.svh
// Assertion macros shared by the assignment reduction solver RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSIGNMENT_REDUCTION_SOLVER_MACROS_SVH
`define ASSIGNMENT_REDUCTION_SOLVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ARS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ars_pkg.sv
// Package for the assignment reduction solver: defaults, FSM and step codes,
// memory control struct. No dependencies.
`timescale 1ns / 1ps

package ars_pkg;

    localparam int MAX_N_DEF     = 16;
    localparam int COST_BITS_DEF = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_PASS,
        S_LINE,
        S_SCAN_RD,
        S_SCAN_USE,
        S_LINE_END,
        S_SUB_RD,
        S_SUB_WR,
        S_NEXT_LINE,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        STEP_ROW_RED,
        STEP_COL_RED,
        STEP_ROW_ZERO,
        STEP_COL_ZERO
    } step_t;

    typedef struct packed {
        logic copy_rd;
        logic work_rd;
        logic work_wr;
    } mem_ctl_t;

endpackage

// File: hw/rtl/assignment_reduction_solver.sv
// Channel  | dir | words
// s_*      | in  | cost entry writes (tuser=0) and solve commands (tuser=1)
// m_*      | out | one result per row on a solve, tlast on row n-1
// cfg_*    | in  | size_in_use, always ready
// A solve copies the full cost memory, then runs up to n passes of four steps;
// each step reads every active line, and a reduction that subtracts adds a
// read-modify-write sweep over the active entries of that line.
// Results leave through a one-word output register; a stalled m_tready holds the
// sequencer. Synchronous active-low reset clears control state only.
// Depends on ars_pkg, ars_mem, ars_ctrl.
`timescale 1ns / 1ps

module assignment_reduction_solver #(
    parameter int MAX_N     = ars_pkg::MAX_N_DEF,
    parameter int COST_BITS = ars_pkg::COST_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[3:0], col_index[7:4], cost[23:8]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // worker_row[3:0], job_col[7:4]
    output logic [0:0]  m_tuser,   // assigned[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import ars_pkg::*;

    localparam int IDX_W  = $clog2(MAX_N);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int SZ_W   = $clog2(MAX_N + 1) + 5;

    logic [4:0]           size_reg;
    logic [SZ_W-1:0]      size_ext;
    logic [SZ_W-1:0]      n_clamp;
    logic [SZ_W-1:0]      n_last_w;
    logic [IDX_W-1:0]     n_last;
    logic                 accept;
    logic                 cost_we;
    logic [IDX_W+3:0]     row_x;
    logic [IDX_W+3:0]     col_x;
    logic [COST_BITS+15:0] cost_x;
    logic                 idle;
    logic                 start;
    mem_ctl_t             ctl;
    logic [ADDR_W-1:0]    addr;
    logic [COST_BITS-1:0] work_wdata;
    logic [COST_BITS-1:0] cost_rdata;
    logic [COST_BITS-1:0] work_rdata;
    logic [3:0]           worker_row;
    logic [3:0]           job_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 5'd16;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    always_comb begin
        size_ext = {{(SZ_W-5){1'b0}}, size_reg};
        if (size_ext == '0) begin
            n_clamp = SZ_W'(1);
        end else if (size_ext > SZ_W'(MAX_N)) begin
            n_clamp = SZ_W'(MAX_N);
        end else begin
            n_clamp = size_ext;
        end
        n_last_w = n_clamp - 1'b1;
    end
    assign n_last = n_last_w[IDX_W-1:0];

    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && s_tuser[0];
    assign row_x    = {{IDX_W{1'b0}}, s_tdata[3:0]};
    assign col_x    = {{IDX_W{1'b0}}, s_tdata[7:4]};
    assign cost_x   = {{COST_BITS{1'b0}}, s_tdata[23:8]};
    assign cost_we  = accept && !s_tuser[0]
                      && (row_x < (IDX_W+4)'(MAX_N)) && (col_x < (IDX_W+4)'(MAX_N));

    ars_mem #(
        .MAX_N     (MAX_N),
        .COST_BITS (COST_BITS)
    ) u_mem (
        .aclk       (aclk),
        .cost_we    (cost_we),
        .cost_waddr ({row_x[IDX_W-1:0], col_x[IDX_W-1:0]}),
        .cost_wdata (cost_x[COST_BITS-1:0]),
        .ctl        (ctl),
        .addr       (addr),
        .work_wdata (work_wdata),
        .cost_rdata (cost_rdata),
        .work_rdata (work_rdata)
    );

    ars_ctrl #(
        .MAX_N     (MAX_N),
        .COST_BITS (COST_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .n_last     (n_last),
        .idle       (idle),
        .ctl        (ctl),
        .addr       (addr),
        .work_wdata (work_wdata),
        .cost_rdata (cost_rdata),
        .work_rdata (work_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .worker_row (worker_row),
        .job_col    (job_col),
        .assigned   (m_tuser[0]),
        .last       (m_tlast)
    );

    assign m_tdata = {job_col, worker_row};

endmodule

// File: hw/rtl/ars_mem.sv
// Cost and work matrix memories with registered reads.
// Depends on ars_pkg.
`timescale 1ns / 1ps

module ars_mem #(
    parameter int MAX_N     = ars_pkg::MAX_N_DEF,
    parameter int COST_BITS = ars_pkg::COST_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   cost_we,
    input  logic [2*$clog2(MAX_N)-1:0]             cost_waddr,
    input  logic [COST_BITS-1:0]                   cost_wdata,
    input  ars_pkg::mem_ctl_t                      ctl,
    input  logic [2*$clog2(MAX_N)-1:0]             addr,
    input  logic [COST_BITS-1:0]                   work_wdata,
    output logic [COST_BITS-1:0]                   cost_rdata,
    output logic [COST_BITS-1:0]                   work_rdata
);
    import ars_pkg::*;

    localparam int ADDR_W    = 2 * $clog2(MAX_N);
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [COST_BITS-1:0] cost_mem [MEM_DEPTH];
    logic [COST_BITS-1:0] work_mem [MEM_DEPTH];
    logic [COST_BITS-1:0] cost_rdata_reg;
    logic [COST_BITS-1:0] work_rdata_reg;

    always_ff @(posedge aclk) begin
        if (cost_we) begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        if (ctl.copy_rd) begin
            cost_rdata_reg <= cost_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.work_wr) begin
            work_mem[addr] <= work_wdata;
        end
        if (ctl.work_rd) begin
            work_rdata_reg <= work_mem[addr];
        end
    end

    assign cost_rdata = cost_rdata_reg;
    assign work_rdata = work_rdata_reg;

endmodule

// File: hw/rtl/ars_ctrl.sv
// Solve sequencer: copy, row/column reduction and single-zero passes over the
// work memory, then one result word per row. Depends on ars_pkg, macros header.
`timescale 1ns / 1ps

`include "assignment_reduction_solver_macros.svh"

module ars_ctrl #(
    parameter int MAX_N     = ars_pkg::MAX_N_DEF,
    parameter int COST_BITS = ars_pkg::COST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [$clog2(MAX_N)-1:0]       n_last,
    output logic                           idle,
    output ars_pkg::mem_ctl_t              ctl,
    output logic [2*$clog2(MAX_N)-1:0]     addr,
    output logic [COST_BITS-1:0]           work_wdata,
    input  logic [COST_BITS-1:0]           cost_rdata,
    input  logic [COST_BITS-1:0]           work_rdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [3:0]                     worker_row,
    output logic [3:0]                     job_col,
    output logic                           assigned,
    output logic                           last
);
    import ars_pkg::*;

    localparam int IDX_W  = $clog2(MAX_N);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int PASS_W = IDX_W + 1;

    state_t               state_reg, state_next;
    step_t                step_reg, step_next;
    logic [IDX_W-1:0]     line_reg, line_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic                 any_reg, any_next;
    logic [COST_BITS-1:0] mn_reg, mn_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]     hit_reg, hit_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [ADDR_W-1:0]    copy_reg, copy_next;
    logic [MAX_N-1:0]     row_act_reg, row_act_next;
    logic [MAX_N-1:0]     col_act_reg, col_act_next;
    logic [MAX_N-1:0]     row_asg_reg, row_asg_next;
    logic [IDX_W-1:0]     asg_col_reg [MAX_N];
    logic [IDX_W-1:0]     out_row_reg, out_row_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_rowd_reg;
    logic [IDX_W-1:0]     out_col_reg;
    logic                 out_asg_reg;
    logic                 out_last_reg;

    logic                 row_kind;
    logic                 line_act;
    logic                 cross_act;
    logic                 k_end;
    logic                 line_end;
    logic                 pass_done;
    logic                 do_retire;
    logic [IDX_W-1:0]     ret_row;
    logic [IDX_W-1:0]     ret_col;
    logic                 out_load;
    logic [IDX_W+3:0]     row_ext;
    logic [IDX_W+3:0]     col_ext;

    assign row_kind  = (step_reg == STEP_ROW_RED) || (step_reg == STEP_ROW_ZERO);
    assign line_act  = row_kind ? row_act_reg[line_reg] : col_act_reg[line_reg];
    assign cross_act = row_kind ? col_act_reg[k_reg] : row_act_reg[k_reg];
    assign k_end     = (k_reg == n_last);
    assign line_end  = (line_reg == n_last);
    assign pass_done = (row_act_reg == '0) || (pass_reg == PASS_W'(n_last) + 1'b1);
    assign do_retire = (state_reg == S_LINE_END) && (cnt_reg == 2'd1)
                       && ((step_reg == STEP_ROW_ZERO) || (step_reg == STEP_COL_ZERO));
    assign ret_row   = row_kind ? line_reg : hit_reg;
    assign ret_col   = row_kind ? hit_reg : line_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (start) state_next = S_COPY_RD;
            S_COPY_RD:   state_next = S_COPY_WR;
            S_COPY_WR:   state_next = (copy_reg == '1) ? S_PASS : S_COPY_RD;
            S_PASS:      state_next = pass_done ? S_OUT : S_LINE;
            S_LINE:      state_next = line_act ? S_SCAN_RD : S_NEXT_LINE;
            S_SCAN_RD:   state_next = S_SCAN_USE;
            S_SCAN_USE:  state_next = k_end ? S_LINE_END : S_SCAN_RD;
            S_LINE_END: begin
                if (((step_reg == STEP_ROW_RED) || (step_reg == STEP_COL_RED))
                    && any_reg && (mn_reg != '0)) begin
                    state_next = S_SUB_RD;
                end else begin
                    state_next = S_NEXT_LINE;
                end
            end
            S_SUB_RD: begin
                if (cross_act) begin
                    state_next = S_SUB_WR;
                end else if (k_end) begin
                    state_next = S_NEXT_LINE;
                end
            end
            S_SUB_WR:    state_next = k_end ? S_NEXT_LINE : S_SUB_RD;
            S_NEXT_LINE: begin
                if (line_end && (step_reg == STEP_COL_ZERO)) begin
                    state_next = S_PASS;
                end else begin
                    state_next = S_LINE;
                end
            end
            S_OUT:       if (out_load && (out_row_reg == n_last)) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // memory control outputs
    always_comb begin
        ctl        = '0;
        addr       = row_kind ? {line_reg, k_reg} : {k_reg, line_reg};
        work_wdata = work_rdata - mn_reg;
        case (state_reg)
            S_COPY_RD: begin
                ctl.copy_rd = 1'b1;
                addr        = copy_reg;
            end
            S_COPY_WR: begin
                ctl.work_wr = 1'b1;
                addr        = copy_reg;
                work_wdata  = cost_rdata;
            end
            S_SCAN_RD: ctl.work_rd = 1'b1;
            S_SUB_RD:  ctl.work_rd = cross_act;
            S_SUB_WR:  ctl.work_wr = 1'b1;
            default:   ctl = '0;
        endcase
    end

    // datapath next values
    always_comb begin
        step_next      = step_reg;
        line_next      = line_reg;
        k_next         = k_reg;
        any_next       = any_reg;
        mn_next        = mn_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        pass_next      = pass_reg;
        copy_next      = copy_reg;
        row_act_next   = row_act_reg;
        col_act_next   = col_act_reg;
        row_asg_next   = row_asg_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    copy_next    = '0;
                    pass_next    = '0;
                    row_asg_next = '0;
                    for (int i = 0; i < MAX_N; i++) begin
                        row_act_next[i] = (IDX_W'(i) <= n_last);
                        col_act_next[i] = (IDX_W'(i) <= n_last);
                    end
                end
            end
            S_COPY_WR: copy_next = copy_reg + 1'b1;
            S_PASS: begin
                step_next    = STEP_ROW_RED;
                line_next    = '0;
                out_row_next = '0;
                if (!pass_done) begin
                    pass_next = pass_reg + 1'b1;
                end
            end
            S_LINE: begin
                k_next   = '0;
                any_next = 1'b0;
                cnt_next = 2'd0;
            end
            S_SCAN_USE: begin
                if (cross_act) begin
                    if (!any_reg || (work_rdata < mn_reg)) begin
                        mn_next  = work_rdata;
                        any_next = 1'b1;
                    end
                    if ((work_rdata == '0) && (cnt_reg != 2'd2)) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == 2'd0) begin
                            hit_next = k_reg;
                        end
                    end
                end
                if (!k_end) begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_LINE_END: begin
                k_next = '0;
                if (do_retire) begin
                    row_asg_next[ret_row] = 1'b1;
                    row_act_next[ret_row] = 1'b0;
                    col_act_next[ret_col] = 1'b0;
                end
            end
            S_SUB_RD: begin
                if (!cross_act && !k_end) begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SUB_WR: begin
                if (!k_end) begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_NEXT_LINE: begin
                if (line_end) begin
                    line_next = '0;
                    case (step_reg)
                        STEP_ROW_RED:  step_next = STEP_COL_RED;
                        STEP_COL_RED:  step_next = STEP_ROW_ZERO;
                        STEP_ROW_ZERO: step_next = STEP_COL_ZERO;
                        default:       step_next = STEP_ROW_RED;
                    endcase
                end else begin
                    line_next = line_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_row_next   = out_row_reg + 1'b1;
                end
            end
            default: begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_ROW_RED;
            pass_reg      <= '0;
            row_act_reg   <= '1;
            col_act_reg   <= '1;
            row_asg_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            row_act_reg   <= row_act_next;
            col_act_reg   <= col_act_next;
            row_asg_reg   <= row_asg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg    <= line_next;
        k_reg       <= k_next;
        any_reg     <= any_next;
        mn_reg      <= mn_next;
        cnt_reg     <= cnt_next;
        hit_reg     <= hit_next;
        copy_reg    <= copy_next;
        out_row_reg <= out_row_next;
        if (do_retire) begin
            asg_col_reg[ret_row] <= ret_col;
        end
        if (out_load) begin
            out_rowd_reg <= out_row_reg;
            out_asg_reg  <= row_asg_reg[out_row_reg];
            out_col_reg  <= row_asg_reg[out_row_reg] ? asg_col_reg[out_row_reg] : '0;
            out_last_reg <= (out_row_reg == n_last);
        end
    end

    assign row_ext    = {4'b0, out_rowd_reg};
    assign col_ext    = {4'b0, out_col_reg};
    assign idle       = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign worker_row = row_ext[3:0];
    assign job_col    = col_ext[3:0];
    assign assigned   = out_asg_reg;
    assign last       = out_last_reg;

    `ARS_ASSERT_NOW(a_retired_inactive, aclk, aresetn, 1'b1, (row_asg_reg & row_act_reg) == '0, "assigned row still active")
    `ARS_ASSERT_NOW(a_pass_bound, aclk, aresetn, 1'b1, pass_reg <= PASS_W'(n_last) + 1'b1, "pass count beyond matrix size")
    `ARS_ASSERT_NOW(a_wr_after_rd, aclk, aresetn, ctl.work_wr, $past(ctl.work_rd || ctl.copy_rd), "work write without preceding read")

endmodule

// File: tb/assignment_reduction_solver_tb.sv
// Self-checking testbench for assignment_reduction_solver: loads cost matrices,
// issues solves and checks every result row against a built-in predictor or directed expected values.
// Depends on ars_pkg and the solver RTL.
`timescale 1ns / 1ps

module assignment_reduction_solver_tb;
    import ars_pkg::*;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;
    localparam int   LONG_HOLD = 3000;

    typedef enum logic [1:0] {OP_CFG, OP_WRITE, OP_SOLVE} op_t;

    typedef struct {
        op_t         op;
        logic [4:0]  size;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] cost;
        bit          typed;
        logic [3:0]  exp_col;
        bit          exp_asg;
    } stim_row_t;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic       asg;
        logic       last;
    } assign_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    logic [15:0]  cost_mem [16][16];
    logic [4:0]   size_reg = 5'd16;
    assign_word_t pending_q [$];
    int           errors = 0;
    int           n_solves = 0;
    int           n_writes = 0;
    int           n_results = 0;
    bit           burst = 1'b0;

    assignment_reduction_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > 16) return 16;
        return int'(size_reg);
    endfunction

    task automatic predict_assignment();
        int n, r, c, cnt, hit, passes;
        logic [15:0] ra, ca, rasg, mn;
        logic [3:0]  acol [16];
        logic [15:0] w [16][16];
        bit any;
        assign_word_t res;
        n = eff_size();
        w = cost_mem;
        ra = '0;
        ca = '0;
        rasg = '0;
        for (r = 0; r < 16; r++) acol[r] = '0;
        for (r = 0; r < n; r++) begin
            ra[r] = 1'b1;
            ca[r] = 1'b1;
        end
        passes = 0;
        while (ra != 0 && passes < n) begin
            passes++;
            for (r = 0; r < n; r++) begin
                if (!ra[r]) continue;
                any = 0;
                mn = 0;
                for (c = 0; c < n; c++)
                    if (ca[c] && (!any || w[r][c] < mn)) begin
                        mn = w[r][c];
                        any = 1;
                    end
                if (any && mn > 0)
                    for (c = 0; c < n; c++) if (ca[c]) w[r][c] -= mn;
            end
            for (c = 0; c < n; c++) begin
                if (!ca[c]) continue;
                any = 0;
                mn = 0;
                for (r = 0; r < n; r++)
                    if (ra[r] && (!any || w[r][c] < mn)) begin
                        mn = w[r][c];
                        any = 1;
                    end
                if (any && mn > 0)
                    for (r = 0; r < n; r++) if (ra[r]) w[r][c] -= mn;
            end
            for (r = 0; r < n; r++) begin
                if (!ra[r]) continue;
                cnt = 0;
                hit = 0;
                for (c = 0; c < n && cnt < 2; c++)
                    if (ca[c] && w[r][c] == 0) begin
                        hit = c;
                        cnt++;
                    end
                if (cnt == 1) begin
                    acol[r] = hit[3:0];
                    rasg[r] = 1'b1;
                    ra[r] = 1'b0;
                    ca[hit] = 1'b0;
                end
            end
            for (c = 0; c < n; c++) begin
                if (!ca[c]) continue;
                cnt = 0;
                hit = 0;
                for (r = 0; r < n && cnt < 2; r++)
                    if (ra[r] && w[r][c] == 0) begin
                        hit = r;
                        cnt++;
                    end
                if (cnt == 1) begin
                    acol[hit] = c[3:0];
                    rasg[hit] = 1'b1;
                    ra[hit] = 1'b0;
                    ca[c] = 1'b0;
                end
            end
        end
        for (r = 0; r < n; r++) begin
            res.row = r[3:0];
            res.asg = rasg[r];
            res.col = rasg[r] ? acol[r] : 4'd0;
            res.last = (r == n - 1);
            pending_q.push_back(res);
        end
    endtask

    function automatic int draw_gap();
        if (burst) return 0;
        return $urandom_range(0, 6);
    endfunction

    // valid stays high across back-to-back words; lowered only before a gap or by go_idle
    task automatic send_word(logic cmd, logic [3:0] row, logic [3:0] col, logic [15:0] cost,
                             bit typed = 0, logic [3:0] exp_col = 0, bit exp_asg = 0);
        int gap;
        assign_word_t res;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {cost, col, row};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        if (cmd == CMD_WRITE) begin
            cost_mem[row][col] = cost;
            n_writes++;
        end else begin
            n_solves++;
            if (typed) begin
                res.row = 4'd0;
                res.col = exp_col;
                res.asg = exp_asg;
                res.last = 1'b1;
                pending_q.push_back(res);
            end else begin
                predict_assignment();
            end
        end
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_size(logic [4:0] value);
        go_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        size_reg = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] draw_cost();
        case ($urandom_range(0, 3))
            0, 1: return 16'($urandom_range(0, 3));
            2: return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic run_phase(logic [4:0] size);
        int n, r, c, k, s;
        write_size(size);
        burst = ($urandom_range(0, 3) == 0);
        n = eff_size();
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                send_word(CMD_WRITE, r[3:0], c[3:0], draw_cost());
        for (s = $urandom_range(1, 3); s > 0; s--) begin
            for (k = $urandom_range(0, 3); k > 0; k--)
                send_word(CMD_WRITE, 4'($urandom), 4'($urandom), draw_cost());
            send_word(CMD_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    // receiver: random stalls, one long hold-off early in the run
    initial begin
        int gap;
        int served;
        served = 0;
        @(posedge aresetn);
        forever begin
            gap = (served == 3) ? LONG_HOLD : draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
            served++;
        end
    end

    always @(negedge aclk) begin
        assign_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[3:0], m_tdata[7:4], m_tuser[0], m_tlast};
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t mismatch: expected no word actual %p", $realtime, got);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    stim_row_t directed [] = '{
        '{OP_CFG,   5'd1,  0, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 0, 16'hFFFF, 0, 0, 0},
        '{OP_SOLVE, 0,     0, 0, 16'h0000, 1, 0, 1},
        '{OP_WRITE, 0,    15, 15, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 0, 16'h0000, 0, 0, 0},
        '{OP_SOLVE, 0,    15, 15, 16'hFFFF, 1, 0, 1},
        '{OP_CFG,   5'd0,  0, 0, 16'h0000, 0, 0, 0},
        '{OP_SOLVE, 0,     0, 0, 16'h0000, 1, 0, 1},
        '{OP_CFG,   5'd2,  0, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 1, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     1, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     1, 1, 16'h0000, 0, 0, 0},
        '{OP_SOLVE, 0,     0, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 1, 16'hFFFF, 0, 0, 0},
        '{OP_WRITE, 0,     1, 0, 16'hFFFF, 0, 0, 0},
        '{OP_SOLVE, 0,     0, 0, 16'h0000, 0, 0, 0},
        '{OP_WRITE, 0,     0, 0, 16'h0007, 0, 0, 0},
        '{OP_WRITE, 0,     1, 1, 16'h0003, 0, 0, 0},
        '{OP_SOLVE, 0,     0, 0, 16'h0000, 0, 0, 0}
    };

    initial begin
        int i, random_start;
        for (i = 0; i < 256; i++) cost_mem[i / 16][i % 16] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[j]) begin
            case (directed[j].op)
                OP_CFG: write_size(directed[j].size);
                OP_WRITE: send_word(CMD_WRITE, directed[j].row, directed[j].col,
                                    directed[j].cost);
                default: send_word(CMD_SOLVE, directed[j].row, directed[j].col,
                                   directed[j].cost, directed[j].typed,
                                   directed[j].exp_col, directed[j].exp_asg);
            endcase
        end
        random_start = n_writes + n_solves;
        while (n_writes + n_solves - random_start < 75)
            run_phase(5'($urandom_range(1, 5)));
        go_idle();
        $display("covered %0d solves, %0d cost writes, %0d result words",
                 n_solves, n_writes, n_results);
        $display("sizes 0, 1, 2 directed, random 1..5 matrices, long output stall");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
